// ===== design/assert_macros.svh =====
// Assertion helpers shared by the block's modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every clock edge outside reset.
`define TPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Never let cond be true outside reset.
`define TPF_ASSERT_NEVER(lbl, cond, msg) \
  `TPF_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/tpf_pkg.sv =====
package tpf_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int MIDQ_DEPTH      = 4;
  localparam int OUTQ_DEPTH      = 16;

  localparam logic [31:0] CUTOFF_SQUARED_RST  = 32'd589824;
  localparam logic [31:0] INV_BIN_SQUARED_RST = 32'd3633607;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PAIR = 1'b1
  } action_t;

  typedef enum logic {
    CFG_CUTOFF_SQUARED  = 1'b0,
    CFG_INV_BIN_SQUARED = 1'b1
  } cfg_idx_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic             is_load;
    logic             skip;
    logic [8:0]       entry_index;
    logic [31:0]      entry_value;
    logic [2:0][23:0] mag;
    logic [2:0]       d_neg;
    logic [31:0]      first_mass;
    logic [31:0]      second_mass;
  } req_t;

  typedef struct packed {
    logic [47:0] force_x;
    logic [47:0] force_y;
    logic [47:0] force_z;
    logic        interacted;
  } res_t;

endpackage

// ===== design/tpf_front.sv =====
module tpf_front
  import tpf_pkg::*;
(
  input  logic             action,
  input  logic [8:0]       entry_index,
  input  logic [31:0]      entry_value,
  input  logic [2:0][31:0] first_pos,
  input  logic [2:0][31:0] second_pos,
  input  logic [31:0]      first_mass,
  input  logic [31:0]      second_mass,
  input  logic             same_particle,
  output req_t             req
);

  logic [2:0][32:0] diff;
  logic [2:0][32:0] mag_full;
  logic [2:0]       far;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {first_pos[k][31], first_pos[k]} - {second_pos[k][31], second_pos[k]};
      mag_full[k] = diff[k][32] ? (~diff[k] + 33'd1) : diff[k];
      // any axis at or beyond 2^24 is outside every cutoff
      far[k]      = |mag_full[k][32:24];
    end
  end

  always_comb begin
    req.is_load     = (action == ACT_LOAD);
    req.skip        = same_particle | (|far);
    req.entry_index = entry_index;
    req.entry_value = entry_value;
    for (int k = 0; k < 3; k++) begin
      req.mag[k]   = mag_full[k][23:0];
      req.d_neg[k] = diff[k][32];
    end
    req.first_mass  = first_mass;
    req.second_mass = second_mass;
  end

endmodule

// ===== design/tpf_fifo.sv =====
`include "assert_macros.svh"

module tpf_fifo
  import tpf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MIDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

  `TPF_ASSERT_NEVER(a_fifo_overflow, wr_en && full, "write into a full queue")
  `TPF_ASSERT_NEVER(a_fifo_underflow, rd_en && empty, "read from an empty queue")

endmodule

// ===== design/tpf_back.sv =====
`include "assert_macros.svh"

module tpf_back
  import tpf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int OQ_DEPTH    = OUTQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  req_t        req,
  input  logic        req_valid,
  output logic        req_pop,
  input  logic [31:0] cutoff_squared,
  input  logic [31:0] inv_bin_squared,
  input  logic        res_taken,
  output res_t        res,
  output logic        res_valid
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int IW     = $clog2(OQ_DEPTH + 1);
  localparam int NSTAGE = 12;

  typedef struct packed {
    logic valid;
    logic is_load;
    logic skip;
  } ctl_t;

  ctl_t ctl_r [NSTAGE:1];

  logic [IW-1:0] inflight_r, inflight_nxt;
  logic          issue;

  // issue a load whenever one is queued, a pair only while the result queue has room for every pair still in flight
  assign issue   = req_valid && (req.is_load || (inflight_r < IW'(OQ_DEPTH)));
  assign req_pop = issue;

  always_comb begin
    inflight_nxt = inflight_r;
    if ((issue && !req.is_load) && !res_taken) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (!(issue && !req.is_load) && res_taken) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  // stage 2 adds the cutoff test to the skip flag
  logic [49:0] d2;
  logic        beyond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      for (int i = 1; i <= NSTAGE; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      inflight_r <= inflight_nxt;
      ctl_r[1]   <= '{valid: issue, is_load: req.is_load, skip: req.skip};
      ctl_r[2]   <= '{valid: ctl_r[1].valid, is_load: ctl_r[1].is_load,
                      skip: ctl_r[1].skip | beyond};
      for (int i = 3; i <= NSTAGE; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // carried payload
  logic [2:0][23:0] mag_r  [9:1];
  logic [2:0]       dneg_r [9:1];
  logic [63:0]      mm_r   [7:1];
  logic [8:0]       idx_r  [3:1];
  logic [31:0]      val_r  [3:1];

  always_ff @(posedge clk) begin
    mag_r[1]  <= req.mag;
    dneg_r[1] <= req.d_neg;
    mm_r[1]   <= {32'd0, req.first_mass} * {32'd0, req.second_mass};
    idx_r[1]  <= req.entry_index;
    val_r[1]  <= req.entry_value;
    for (int i = 2; i <= 9; i++) begin
      mag_r[i]  <= mag_r[i-1];
      dneg_r[i] <= dneg_r[i-1];
    end
    for (int i = 2; i <= 7; i++) begin
      mm_r[i] <= mm_r[i-1];
    end
    for (int i = 2; i <= 3; i++) begin
      idx_r[i] <= idx_r[i-1];
      val_r[i] <= val_r[i-1];
    end
  end

  // stage 1: squares
  logic [2:0][47:0] s1_sq_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_sq_r[k] <= {24'd0, req.mag[k]} * {24'd0, req.mag[k]};
    end
  end

  // stage 2: squared distance and cutoff test
  assign d2     = {2'b00, s1_sq_r[0]} + {2'b00, s1_sq_r[1]} + {2'b00, s1_sq_r[2]};
  assign beyond = (d2 >= {2'b00, cutoff_squared, 16'd0});

  logic [33:0] s2_d2s_r;
  always_ff @(posedge clk) begin
    s2_d2s_r <= d2[49:16];
  end

  // stage 3: table coordinate
  logic [65:0] s3_ksi_r;
  always_ff @(posedge clk) begin
    s3_ksi_r <= {32'd0, s2_d2s_r} * {34'd0, inv_bin_squared};
  end

  // stage 4: table access; loads write here so they stay in order with reads
  logic [33:0]   tcoord;
  logic          at_end;
  logic [AW-1:0] lo_addr, hi_addr, ld_addr;
  logic          ld_en;
  logic [31:0]   tbl_mem [TABLE_DEPTH];
  logic [31:0]   s4_lo_r, s4_hi_r;
  logic [23:0]   s4_w_r;

  assign tcoord  = s3_ksi_r[65:32];
  assign at_end  = (tcoord >= 34'(TABLE_DEPTH - 1));
  assign lo_addr = at_end ? AW'(TABLE_DEPTH - 1) : tcoord[AW-1:0];
  assign hi_addr = at_end ? AW'(TABLE_DEPTH - 1) : tcoord[AW-1:0] + 1'b1;
  assign ld_addr = AW'(idx_r[3]);
  assign ld_en   = ctl_r[3].valid && ctl_r[3].is_load &&
                   ({23'd0, idx_r[3]} < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (ld_en) begin
      tbl_mem[ld_addr] <= val_r[3];
    end
    s4_lo_r <= tbl_mem[lo_addr];
    s4_hi_r <= tbl_mem[hi_addr];
    s4_w_r  <= s3_ksi_r[31:8];
  end

  // stage 5: neighbour difference
  logic signed [32:0] s5_diff_r;
  logic [31:0]        s5_lo_r;
  logic [23:0]        s5_w_r;
  always_ff @(posedge clk) begin
    s5_diff_r <= {s4_hi_r[31], s4_hi_r} - {s4_lo_r[31], s4_lo_r};
    s5_lo_r   <= s4_lo_r;
    s5_w_r    <= s4_w_r;
  end

  // stage 6: weighted difference
  logic signed [57:0] s6_prod_r;
  logic signed [24:0] w_s;
  logic [31:0]        s6_lo_r;
  assign w_s = {1'b0, s5_w_r};
  always_ff @(posedge clk) begin
    s6_prod_r <= s5_diff_r * w_s;
    s6_lo_r   <= s5_lo_r;
  end

  // stage 7: interpolated value, split into sign and magnitude
  logic [33:0] f34, f34_neg;
  logic [31:0] s7_fmag_r;
  logic        s7_fneg_r;
  assign f34     = {{2{s6_lo_r[31]}}, s6_lo_r} + s6_prod_r[57:24];
  assign f34_neg = ~f34 + 34'd1;
  always_ff @(posedge clk) begin
    s7_fneg_r <= f34[31];
    s7_fmag_r <= f34[31] ? f34_neg[31:0] : f34[31:0];
  end

  // stage 8: mass product times table value, two halves
  logic [63:0] s8_pph_r, s8_ppl_r;
  logic        s8_fneg_r;
  always_ff @(posedge clk) begin
    s8_pph_r  <= {32'd0, mm_r[7][63:32]} * {32'd0, s7_fmag_r};
    s8_ppl_r  <= {32'd0, mm_r[7][31:0]} * {32'd0, s7_fmag_r};
    s8_fneg_r <= s7_fneg_r;
  end

  // stage 9: combine and saturate the scaled magnitude
  logic [64:0] pfull;
  logic [62:0] s9_p_r;
  logic        s9_fneg_r;
  assign pfull = {1'b0, s8_pph_r} + {33'd0, s8_ppl_r[63:32]};
  always_ff @(posedge clk) begin
    s9_p_r    <= (|pfull[64:63]) ? {63{1'b1}} : pfull[62:0];
    s9_fneg_r <= s8_fneg_r;
  end

  // stage 10: magnitude times displacement, two halves per axis
  logic [2:0][54:0] s10_qh_r;
  logic [2:0][55:0] s10_ql_r;
  logic [2:0]       s10_neg_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s10_qh_r[k]  <= {24'd0, s9_p_r[62:32]} * {31'd0, mag_r[9][k]};
      s10_ql_r[k]  <= {24'd0, s9_p_r[31:0]} * {32'd0, mag_r[9][k]};
      s10_neg_r[k] <= s9_fneg_r ^ dneg_r[9][k];
    end
  end

  // stage 11: combine, shift, saturate per sign
  localparam logic [47:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] LIM_NEG = 48'h8000_0000_0000;
  logic [2:0][86:0] qfull;
  logic [2:0][47:0] lim;
  logic [2:0][47:0] s11_m_r;
  logic [2:0]       s11_neg_r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qfull[k] = {s10_qh_r[k], 32'd0} + {31'd0, s10_ql_r[k]};
      lim[k]   = s10_neg_r[k] ? LIM_NEG : LIM_POS;
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s11_m_r[k]   <= (qfull[k][86:16] > {23'd0, lim[k]}) ? lim[k] : qfull[k][63:16];
      s11_neg_r[k] <= s10_neg_r[k];
    end
  end

  // stage 12: apply sign, zero skipped pairs
  logic [2:0][47:0] sgn;
  logic [2:0][47:0] s12_f_r;
  logic             s12_hit_r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sgn[k] = ctl_r[11].skip ? 48'd0 :
               (s11_neg_r[k] ? (~s11_m_r[k] + 48'd1) : s11_m_r[k]);
    end
  end
  always_ff @(posedge clk) begin
    s12_f_r   <= sgn;
    s12_hit_r <= !ctl_r[11].skip;
  end

  assign res_valid      = ctl_r[NSTAGE].valid && !ctl_r[NSTAGE].is_load;
  assign res.force_x    = s12_f_r[0];
  assign res.force_y    = s12_f_r[1];
  assign res.force_z    = s12_f_r[2];
  assign res.interacted = s12_hit_r;

  `TPF_ASSERT(a_credit_bound, inflight_r <= IW'(OQ_DEPTH), "pairs in flight exceed queue room")
  `TPF_ASSERT(a_skip_zero, (res_valid && !res.interacted) |-> (s12_f_r == '0), "skipped pair has force")
  `TPF_ASSERT_NEVER(a_no_stray_take, res_taken && (inflight_r == '0), "result taken with none in flight")

endmodule

// ===== design/tabulated_pair_force_top.sv =====
// Channel   | Ports                               | Moves
// ----------+-------------------------------------+--------------------------------
// input     | push, full, in_*                    | one request: table load or pair
// result    | empty, pop, out_*                   | one force per pair request
// config    | cfg_we, cfg_index, cfg_data         | register write, no wait
//
// A request is taken in every cycle while full is low; a pair taken from the request
// queue passes through the back pipeline, is written into the result queue and can
// then be popped from there. Table loads write the table and give no result.
// Reset is synchronous on rst_n and clears queues, pipeline valids and registers;
// the force table is not cleared and must be loaded before a pair reads it.
// The back issues a pair only while the 16-entry result queue has room for every pair in
// flight, so a stalled consumer fills that queue and then the 4-entry request queue.
module tabulated_pair_force_top
  import tpf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [8:0]  in_entry_index,
  input  logic [31:0] in_entry_value,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  input  logic [31:0] in_first_mass,
  input  logic [31:0] in_second_mass,
  input  logic        in_same_particle,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [47:0] out_force_x,
  output logic [47:0] out_force_y,
  output logic [47:0] out_force_z,
  output logic        out_interacted,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic [31:0] cutoff_squared_r;
  logic [31:0] inv_bin_squared_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_squared_r  <= CUTOFF_SQUARED_RST;
      inv_bin_squared_r <= INV_BIN_SQUARED_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CUTOFF_SQUARED) begin
        cutoff_squared_r <= cfg_data;
      end
      if (cfg_index == CFG_INV_BIN_SQUARED) begin
        inv_bin_squared_r <= cfg_data;
      end
    end
  end

  // front: classify the request and take displacements apart into sign and size
  req_t front_req;

  tpf_front u_front (
    .action        (in_action),
    .entry_index   (in_entry_index),
    .entry_value   (in_entry_value),
    .first_pos     ({in_first_z, in_first_y, in_first_x}),
    .second_pos    ({in_second_z, in_second_y, in_second_x}),
    .first_mass    (in_first_mass),
    .second_mass   (in_second_mass),
    .same_particle (in_same_particle),
    .req           (front_req)
  );

  // short request queue: lets the front keep accepting while the back waits
  logic req_push, req_pop, req_empty;
  req_t back_req;

  assign req_push = push && !full;

  tpf_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (MIDQ_DEPTH)
  ) u_reqq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (req_push),
    .wr_data (front_req),
    .rd_en   (req_pop),
    .rd_data (back_req),
    .full    (full),
    .empty   (req_empty)
  );

  // back: table pipeline; hold issue while result room runs out
  res_t back_res;
  logic back_res_valid;
  logic res_taken;

  assign res_taken = pop && !empty;

  tpf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OQ_DEPTH    (OUTQ_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (back_req),
    .req_valid       (!req_empty),
    .req_pop         (req_pop),
    .cutoff_squared  (cutoff_squared_r),
    .inv_bin_squared (inv_bin_squared_r),
    .res_taken       (res_taken),
    .res             (back_res),
    .res_valid       (back_res_valid)
  );

  // result queue: parts the pipeline from a stalling consumer
  res_t head_res;
  logic res_full;

  tpf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_res_valid),
    .wr_data (back_res),
    .rd_en   (res_taken),
    .rd_data (head_res),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_force_x    = head_res.force_x;
  assign out_force_y    = head_res.force_y;
  assign out_force_z    = head_res.force_z;
  assign out_interacted = head_res.interacted;

  `TPF_ASSERT_NEVER(a_resq_overrun, back_res_valid && res_full && !res_taken, "result queue overrun")

endmodule

// ===== dv/tabulated_pair_force_checker.sv =====
module tabulated_pair_force_checker
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_action,
  input  logic [8:0]  in_entry_index,
  input  logic [31:0] in_entry_value,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  input  logic [31:0] in_first_mass,
  input  logic [31:0] in_second_mass,
  input  logic        in_same_particle,
  input  logic        empty,
  input  logic        pop,
  input  logic [47:0] out_force_x,
  input  logic [47:0] out_force_y,
  input  logic [47:0] out_force_z,
  input  logic        out_interacted,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  logic signed [31:0] force_words [DEPTH];
  logic [31:0]        cutoff_sq;
  logic [31:0]        inv_bin_sq;
  res_t               force_queue [$];

  function automatic longint unsigned clamp_product(longint unsigned a, longint unsigned b,
                                                    int unsigned s, longint unsigned lim);
    logic [127:0] prod;
    prod = (128'(a) * 128'(b)) >> s;
    return (prod > 128'(lim)) ? lim : prod[63:0];
  endfunction

  function automatic res_t pair_force(logic [2:0][31:0] a, logic [2:0][31:0] b,
                                      logic [31:0] m1, logic [31:0] m2, logic same);
    res_t             r;
    longint           disp [3];
    longint unsigned  mag [3];
    longint unsigned  d2;
    logic [127:0]     ksi;
    logic [127:0]     bin;
    longint unsigned  frac;
    longint           lo;
    longint           hi;
    longint           f;
    longint unsigned  p;
    longint unsigned  m;
    longint unsigned  lim;
    logic [47:0]      v;
    bit               neg;
    r  = '0;
    d2 = 0;
    if (same) return r;
    for (int k = 0; k < 3; k++) begin
      disp[k] = longint'($signed(a[k])) - longint'($signed(b[k]));
      mag[k]  = (disp[k] < 0) ? longint'(-disp[k]) : longint'(disp[k]);
      if (mag[k] >= 64'h100_0000) return r;
      d2 += mag[k] * mag[k];
    end
    if (d2 >= (64'(cutoff_sq) << 16)) return r;
    ksi  = 128'(d2 >> 16) * 128'(inv_bin_sq);
    bin  = ksi >> 32;
    frac = 64'(ksi[31:8]);
    if (bin >= 128'(DEPTH - 1)) begin
      f = longint'(force_words[DEPTH-1]);
    end else begin
      lo = longint'(force_words[bin[8:0]]);
      hi = longint'(force_words[bin[8:0] + 9'd1]);
      f  = lo + (((hi - lo) * longint'(frac)) >>> 24);
    end
    p = clamp_product(64'(m1) * 64'(m2), (f < 0) ? -f : f, 32, 64'h7FFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 3; k++) begin
      neg = (f < 0) != (disp[k] < 0);
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      m   = clamp_product(p, mag[k], 16, lim);
      v   = neg ? 48'(-m) : 48'(m);
      case (k)
        0: r.force_x = v;
        1: r.force_y = v;
        default: r.force_z = v;
      endcase
    end
    r.interacted = 1'b1;
    return r;
  endfunction

  assign pending = force_queue.size();

  initial fails = 0;

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      cutoff_sq  <= CUTOFF_SQUARED_RST;
      inv_bin_sq <= INV_BIN_SQUARED_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CUTOFF_SQUARED:  cutoff_sq  <= cfg_data;
          CFG_INV_BIN_SQUARED: inv_bin_sq <= cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (action_t'(in_action) == ACT_LOAD) begin
          if (in_entry_index < DEPTH) force_words[in_entry_index] = in_entry_value;
        end else begin
          force_queue = {force_queue,
                         pair_force({in_first_z, in_first_y, in_first_x},
                                    {in_second_z, in_second_y, in_second_x},
                                    in_first_mass, in_second_mass, in_same_particle)};
        end
      end
      if (pop && !empty) begin
        got = '{out_force_x, out_force_y, out_force_z, out_interacted};
        if (force_queue.size() == 0) begin
          fails++;
          if (fails <= 10) $display("force result with none expected: %h", got);
        end else begin
          want = force_queue.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("force mismatch: exp x=%h y=%h z=%h i=%b  got x=%h y=%h z=%h i=%b",
                       want.force_x, want.force_y, want.force_z, want.interacted,
                       got.force_x, got.force_y, got.force_z, got.interacted);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_tabulated_pair_force_top.sv =====
module tb_tabulated_pair_force_top;
  import tpf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_action;
  logic [8:0]  in_entry_index;
  logic [31:0] in_entry_value;
  logic [31:0] in_first_x;
  logic [31:0] in_first_y;
  logic [31:0] in_first_z;
  logic [31:0] in_second_x;
  logic [31:0] in_second_y;
  logic [31:0] in_second_z;
  logic [31:0] in_first_mass;
  logic [31:0] in_second_mass;
  logic        in_same_particle;
  logic        empty;
  logic        pop;
  logic [47:0] out_force_x;
  logic [47:0] out_force_y;
  logic [47:0] out_force_z;
  logic        out_interacted;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int fails;
  int pending;

  // Flow control knobs for the sender and the receiver, and a stimulus-done flag
  bit tx_eager;
  bit rx_eager;
  bit rx_hold;
  bit stim_done;

  tabulated_pair_force_top i_dut (.*);

  tabulated_pair_force_checker i_checker (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_tabulated_pair_force_top NOT OK");
    $finish;
  end

  // Receiver: random pauses, eager stretches, and a long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, 16);
      if (gap > 0 || rx_hold) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send(input logic act, input logic [8:0] idx, input logic [31:0] val,
                      input logic [2:0][31:0] a, input logic [2:0][31:0] b,
                      input logic [31:0] m1, input logic [31:0] m2, input logic same);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    in_action        <= act;
    in_entry_index   <= idx;
    in_entry_value   <= val;
    in_first_x       <= a[0];
    in_first_y       <= a[1];
    in_first_z       <= a[2];
    in_second_x      <= b[0];
    in_second_y      <= b[1];
    in_second_z      <= b[2];
    in_first_mass    <= m1;
    in_second_mass   <= m2;
    in_same_particle <= same;
    do @(posedge clk); while (full);
  endtask

  task automatic load(input logic [8:0] idx, input logic [31:0] val);
    send(ACT_LOAD, idx, val, {3{$urandom}}, {3{$urandom}}, $urandom, $urandom,
         1'($urandom));
  endtask

  // Pair with a chosen displacement first - second, placed at a random origin
  task automatic pair(input int dx, input int dy, input int dz,
                      input logic [31:0] m1, input logic [31:0] m2, input logic same);
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    int d [3];
    d = '{dx, dy, dz};
    for (int k = 0; k < 3; k++) begin
      a[k] = $signed($urandom) >>> 2;
      b[k] = a[k] - d[k];
    end
    send(ACT_PAIR, 9'($urandom), $urandom, a, b, m1, m2, same);
  endtask

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'h0001_0000;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic int rand_disp(input int reach);
    return $urandom_range(0, 2 * reach) - reach;
  endfunction

  // Idle the block: drain results, then let the back stages empty out
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_burst(input int count);
    int reach;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        tx_eager = ($urandom_range(0, 3) == 0);
        rx_eager = ($urandom_range(0, 3) == 0);
      end
      reach = ($urandom_range(0, 7) == 0) ? 24'hFF_FFFF : 200000;
      case ($urandom_range(0, 9))
        0: load(9'($urandom), $urandom);
        1: send(ACT_PAIR, 9'($urandom), $urandom, {3{$urandom}}, {3{$urandom}},
                $urandom, $urandom, 1'($urandom));
        2: pair(rand_disp(reach), rand_disp(reach), rand_disp(reach),
                rand_mass(), rand_mass(), 1'b1);
        default: pair(rand_disp(reach), rand_disp(reach), rand_disp(reach),
                      rand_mass(), rand_mass(), 1'b0);
      endcase
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    push             = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_CUTOFF_SQUARED;
    cfg_data         = '0;
    in_action        = ACT_LOAD;
    in_entry_index   = '0;
    in_entry_value   = '0;
    in_first_x       = '0;
    in_first_y       = '0;
    in_first_z       = '0;
    in_second_x      = '0;
    in_second_y      = '0;
    in_second_z      = '0;
    in_first_mass    = '0;
    in_second_mass   = '0;
    in_same_particle = 1'b0;
    tx_eager         = 1'b1;
    rx_eager         = 1'b0;
    rx_hold          = 1'b0;
    stim_done        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table first so that no pair ever reads an unwritten word;
    // plant both extremes near the start and at the saturating end
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      case (i)
        0, 510:  load(9'(i), 32'h7FFF_FFFF);
        1, 511:  load(9'(i), 32'h8000_0000);
        default: load(9'(i), $urandom);
      endcase
    end
    tx_eager = 1'b0;

    // Directed pairs at reset settings
    pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b1);           // self pair
    pair(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);           // coincident
    pair(32'h0100_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0); // far axis
    pair(0, -32'sh0100_0000, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    pair(196608, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);      // exactly at cutoff
    pair(196607, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);      // just inside
    pair(-1, 1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    pair(100, -100, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);       // saturating force
    pair(-120000, 80000, -30000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    pair(150000, 150000, 0, 32'h0002_0000, 32'h0003_0000, 1'b0);
    load(9'd511, 32'h8000_0000);                                  // rewrite last word

    // Let the block fill against a stalled receiver while requests keep coming
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        tx_eager = 1'b1;
        random_burst(80);
        tx_eager = 1'b0;
      end
    join
    random_burst(120);

    // Sweep the registers through their extremes and random settings, idle between each setting
    drain();
    write_reg(CFG_CUTOFF_SQUARED, 32'h0000_0000);                // nothing interacts
    write_reg(CFG_INV_BIN_SQUARED, $urandom);
    random_burst(100);
    drain();
    write_reg(CFG_CUTOFF_SQUARED, 32'hFFFF_FFFF);
    write_reg(CFG_INV_BIN_SQUARED, 32'hFFFF_FFFF);              // table end wherever the squared distance reaches 2^25
    pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    pair(24'hFF_FFFF, -24'shFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    random_burst(150);
    drain();
    write_reg(CFG_INV_BIN_SQUARED, 32'h0000_0000);              // always bin zero
    write_reg(CFG_CUTOFF_SQUARED, $urandom);
    random_burst(150);
    drain();
    write_reg(CFG_CUTOFF_SQUARED, $urandom_range(32'h0001_0000, 32'h0040_0000));
    write_reg(CFG_INV_BIN_SQUARED, $urandom_range(32'h0010_0000, 32'h0100_0000));
    random_burst(150);
    drain();
    write_reg(CFG_CUTOFF_SQUARED, CUTOFF_SQUARED_RST);
    write_reg(CFG_INV_BIN_SQUARED, INV_BIN_SQUARED_RST);
    random_burst(230);

    // Wait out every outstanding force, then a little beyond the pipeline depth
    push <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_tabulated_pair_force_top OK");
    end else begin
      $display("tb_tabulated_pair_force_top NOT OK");
    end
    $finish;
  end

endmodule
